// ===== rtl/xyz_image_normal_estimator_top_macros.svh =====
// Assertion macros shared by the normal estimator RTL.
// No dependencies; included inside module bodies.
`ifndef XYZ_IMAGE_NORMAL_ESTIMATOR_TOP_MACROS_SVH
`define XYZ_IMAGE_NORMAL_ESTIMATOR_TOP_MACROS_SVH

// same-cycle implication
`define XYZ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define XYZ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/xyz_ne_pkg.sv =====
// Types and constants of the XYZ image normal estimator.
// No dependencies; used by xyz_ne_norm and the top level.
package xyz_ne_pkg;

    localparam int COORD_W    = 20;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = CROSS_W - 1;
    localparam int LIM_W      = 30;
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int NORM_F     = 14;
    localparam int NORM_W     = 16;
    localparam int QUO_W      = NORM_F + 1;
    localparam int ACC_W      = NORM_F + 5;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int CFG_WW     = 12;
    localparam int CFG_HW     = 13;
    localparam int CFG_DW     = 13;
    localparam int CFG_IW     = 2;
    localparam int NUM_TRI    = 8;

    localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic signed [CROSS_W-1:0] x;
        logic signed [CROSS_W-1:0] y;
        logic signed [CROSS_W-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] z;
    } t_nrm;

endpackage

// ===== rtl/xyz_ne_norm.sv =====
// Iterative fixed-point vector normaliser: range shift, sum of squares,
// bit-pair square root and restoring division. Depends on xyz_ne_pkg.
module xyz_ne_norm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  xyz_ne_pkg::t_vec i_vec,
    output logic             o_done,
    output xyz_ne_pkg::t_nrm o_nrm
);
    import xyz_ne_pkg::*;
    `include "xyz_image_normal_estimator_top_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SHFT = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_DLD  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]              r_state;
    logic [MAG_W-1:0]        r_mag [3];
    logic [2:0]              r_neg;
    logic [1:0]              r_j;
    logic [SUM_W-1:0]        r_v;
    logic [SUM_W-1:0]        r_res;
    logic [SUM_W-1:0]        r_bit;
    logic [3:0]              r_cnt;
    logic [ROOT_W:0]         r_rem;
    logic [QUO_W-1:0]        r_num;
    logic [QUO_W-1:0]        r_quo;
    logic signed [NORM_W-1:0] r_out [3];

    logic [LIM_W-1:0]        w_msel;
    logic [2*LIM_W-1:0]      w_sq;
    logic [SUM_W-1:0]        w_trial;
    logic [ROOT_W:0]         w_den;
    logic [LIM_W+QUO_W:0]    w_numer;
    logic [ROOT_W+1:0]       w_t;
    logic                    w_qb;
    logic [QUO_W-1:0]        w_q;
    logic                    w_big;

    always_comb begin
        w_msel  = r_mag[r_j][LIM_W-1:0];
        w_sq    = w_msel * w_msel;
        w_trial = r_res + r_bit;
        w_den   = {r_res[ROOT_W-1:0], 1'b0};
        w_numer = {1'b0, w_msel, {QUO_W{1'b0}}}
                + (LIM_W+QUO_W+1)'(r_res[ROOT_W-1:0]);
        w_t     = {r_rem, r_num[QUO_W-1]};
        w_qb    = (w_t >= {1'b0, w_den});
        w_q     = {r_quo[QUO_W-2:0], w_qb};
        w_big   = (|r_mag[0][MAG_W-1:LIM_W]) | (|r_mag[1][MAG_W-1:LIM_W])
                | (|r_mag[2][MAG_W-1:LIM_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mag[0] <= i_vec.x[CROSS_W-1] ? MAG_W'(-i_vec.x) : MAG_W'(i_vec.x);
                        r_mag[1] <= i_vec.y[CROSS_W-1] ? MAG_W'(-i_vec.y) : MAG_W'(i_vec.y);
                        r_mag[2] <= i_vec.z[CROSS_W-1] ? MAG_W'(-i_vec.z) : MAG_W'(i_vec.z);
                        r_neg    <= {i_vec.z[CROSS_W-1], i_vec.y[CROSS_W-1],
                                     i_vec.x[CROSS_W-1]};
                        r_state  <= S_SHFT;
                    end
                end
                S_SHFT: begin
                    if (w_big) begin
                        r_mag[0] <= r_mag[0] >> 1;
                        r_mag[1] <= r_mag[1] >> 1;
                        r_mag[2] <= r_mag[2] >> 1;
                    end else begin
                        r_v     <= '0;
                        r_j     <= 2'd0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_v <= r_v + SUM_W'(w_sq);
                    if (r_j == 2'd2) begin
                        r_res   <= '0;
                        r_bit   <= SUM_W'(1) << (SUM_W - 2);
                        r_state <= S_ROOT;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                S_ROOT: begin
                    if (r_bit == '0) begin
                        r_j <= 2'd0;
                        if (r_res == '0) begin
                            r_out[0] <= '0;
                            r_out[1] <= '0;
                            r_out[2] <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_DLD;
                        end
                    end else begin
                        if (r_v >= w_trial) begin
                            r_v   <= r_v - w_trial;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_DLD: begin
                    r_rem   <= (ROOT_W+1)'(w_numer[LIM_W+QUO_W:QUO_W]);
                    r_num   <= w_numer[QUO_W-1:0];
                    r_quo   <= '0;
                    r_cnt   <= 4'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_qb ? (ROOT_W+1)'(w_t - {1'b0, w_den}) : w_t[ROOT_W:0];
                    r_num <= {r_num[QUO_W-2:0], 1'b0};
                    r_quo <= w_q;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(QUO_W - 1)) begin
                        r_out[r_j] <= r_neg[r_j] ? -NORM_W'(w_q) : NORM_W'(w_q);
                        if (r_j == 2'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_DLD;
                        end
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done  = (r_state == S_DONE);
    assign o_nrm.x = r_out[0];
    assign o_nrm.y = r_out[1];
    assign o_nrm.z = r_out[2];

    `XYZ_ASSERT_NOW(a_start_idle, i_clk, i_rst_n, i_start, r_state == S_IDLE, "start while busy")
    `XYZ_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_done, r_state == S_IDLE, "no return to idle")
    `XYZ_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_res != '0, "zero divisor")
    `XYZ_ASSERT_NOW(a_unit_range, i_clk, i_rst_n, o_done,
        o_nrm.x <= 16'sd16384 && o_nrm.x >= -16'sd16384 && o_nrm.z <= 16'sd16384, "range")

endmodule

// ===== rtl/xyz_image_normal_estimator_top.sv =====
// Top level of the XYZ image normal estimator: line stores, 3x3 window,
// cross-product sequencer. Depends on xyz_ne_pkg and xyz_ne_norm.
//
//  channel | dir | handshake               | beat
//  in      | in  | i_in_valid / o_in_ready | point_x, point_y, point_z
//  out     | out | o_out_valid/i_out_ready | normal_x/y/z, centre_row/col, last
//  cfg     | in  | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// A border beat passes through S_MEM only; an interior beat makes nine passes
// through the single iterative normaliser (32-step root, three 15-step divides).
// Line stores are read (registered) at the beat and written back in the cycle after it.
// Reset clears control only; line stores need no clearing.
// A result waiting on o_out_valid does not stop the next input beat.
module xyz_image_normal_estimator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [xyz_ne_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [xyz_ne_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [xyz_ne_pkg::COORD_W-1:0] i_point_z,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [xyz_ne_pkg::NORM_W-1:0]  o_normal_x,
    output logic signed [xyz_ne_pkg::NORM_W-1:0]  o_normal_y,
    output logic signed [xyz_ne_pkg::NORM_W-1:0]  o_normal_z,
    output logic [xyz_ne_pkg::ROW_W-1:0]      o_centre_row,
    output logic [xyz_ne_pkg::ADDR_W-1:0]     o_centre_col,
    output logic                              o_last_of_frame,
    input  logic                              i_cfg_we,
    input  logic [xyz_ne_pkg::CFG_IW-1:0]     i_cfg_idx,
    input  logic [xyz_ne_pkg::CFG_DW-1:0]     i_cfg_data
);
    import xyz_ne_pkg::*;
    `include "xyz_image_normal_estimator_top_macros.svh"

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MEM  = 4'd1;
    localparam logic [3:0] S_DIFF = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_TST  = 4'd4;
    localparam logic [3:0] S_TWT  = 4'd5;
    localparam logic [3:0] S_FST  = 4'd6;
    localparam logic [3:0] S_FWT  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    t_point upper_mem  [MAX_WIDTH];
    t_point middle_mem [MAX_WIDTH];

    logic [3:0]         r_state, n_state;
    logic [CFG_WW-1:0]  r_img_w;
    logic [CFG_HW-1:0]  r_img_h;
    logic [ADDR_W-1:0]  r_col, r_addr;
    logic [ROW_W-1:0]   r_row;
    logic               r_emit, r_last;
    logic [ROW_W-1:0]   r_crow;
    logic [ADDR_W-1:0]  r_ccol;
    t_point             r_cur, r_top, r_mid;
    t_point             r_win [6];
    logic [2:0]         r_k;
    logic [2:0]         r_j;
    logic signed [DIFF_W-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic signed [PROD_W-1:0] r_prod [6];
    logic signed [ACC_W-1:0]  r_ax_acc, r_ay_acc, r_az_acc;
    t_nrm               r_fin;
    logic               r_oval;

    logic               w_in_acc, w_out_load;
    logic [CFG_WW-1:0]  w_weff;
    logic [CFG_HW-1:0]  w_heff;
    logic               w_col_end, w_row_end;
    t_point             w_ring [NUM_TRI];
    t_point             w_p, w_q, w_cc;
    logic signed [DIFF_W-1:0] w_ma, w_mb;
    logic               w_start, w_done;
    t_vec               w_vec;
    t_nrm               w_nrm;

    always_comb begin
        w_weff = (r_img_w < CFG_WW'(3)) ? CFG_WW'(3)
               : (r_img_w > CFG_WW'(MAX_WIDTH)) ? CFG_WW'(MAX_WIDTH) : r_img_w;
        w_heff = (r_img_h < CFG_HW'(3)) ? CFG_HW'(3)
               : (r_img_h > CFG_HW'(MAX_HEIGHT)) ? CFG_HW'(MAX_HEIGHT) : r_img_h;
        w_col_end = ({1'b0, r_col} == w_weff - CFG_WW'(1));
        w_row_end = ({1'b0, r_row} == w_heff - CFG_HW'(1));
        w_in_acc  = i_in_valid & o_in_ready;
        w_out_load = (r_state == S_OUT) & (~r_oval | i_out_ready);

        w_ring[0] = r_win[0];
        w_ring[1] = r_win[3];
        w_ring[2] = r_top;
        w_ring[3] = r_mid;
        w_ring[4] = r_cur;
        w_ring[5] = r_win[5];
        w_ring[6] = r_win[2];
        w_ring[7] = r_win[1];
        w_cc = r_win[4];
        w_p  = w_ring[r_k + 3'd1];
        w_q  = w_ring[r_k];

        case (r_j)
            3'd0:    begin w_ma = r_ay; w_mb = r_bz; end
            3'd1:    begin w_ma = r_az; w_mb = r_by; end
            3'd2:    begin w_ma = r_az; w_mb = r_bx; end
            3'd3:    begin w_ma = r_ax; w_mb = r_bz; end
            3'd4:    begin w_ma = r_ax; w_mb = r_by; end
            default: begin w_ma = r_ay; w_mb = r_bx; end
        endcase

        w_start = (r_state == S_TST) | (r_state == S_FST);
        if (r_state == S_FST) begin
            w_vec.x = CROSS_W'(r_ax_acc);
            w_vec.y = CROSS_W'(r_ay_acc);
            w_vec.z = CROSS_W'(r_az_acc);
        end else begin
            w_vec.x = CROSS_W'(r_prod[0]) - CROSS_W'(r_prod[1]);
            w_vec.y = CROSS_W'(r_prod[2]) - CROSS_W'(r_prod[3]);
            w_vec.z = CROSS_W'(r_prod[4]) - CROSS_W'(r_prod[5]);
        end

        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_MEM;
            S_MEM:  n_state = r_emit ? S_DIFF : S_IDLE;
            S_DIFF: n_state = S_MUL;
            S_MUL:  if (r_j == 3'd5) n_state = S_TST;
            S_TST:  n_state = S_TWT;
            S_TWT:  if (w_done) n_state = (r_k == 3'(NUM_TRI - 1)) ? S_FST : S_DIFF;
            S_FST:  n_state = S_FWT;
            S_FWT:  if (w_done) n_state = S_OUT;
            S_OUT:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    xyz_ne_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_vec   (w_vec),
        .o_done  (w_done),
        .o_nrm   (w_nrm)
    );

    // line stores: registered read at beat, write-back in the following cycle
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_top <= upper_mem[r_col];
            r_mid <= middle_mem[r_col];
        end
        if (r_state == S_MEM) begin
            upper_mem[r_addr]  <= r_mid;
            middle_mem[r_addr] <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_img_w <= CFG_WW'(640);
            r_img_h <= CFG_HW'(480);
            r_col   <= '0;
            r_row   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WIDTH: begin
                        r_img_w <= i_cfg_data[CFG_WW-1:0];
                        r_col   <= '0;
                        r_row   <= '0;
                    end
                    REG_HEIGHT: begin
                        r_img_h <= i_cfg_data[CFG_HW-1:0];
                        r_col   <= '0;
                        r_row   <= '0;
                    end
                    default: ;
                endcase
            end else if (w_in_acc) begin
                if (w_col_end) begin
                    r_col <= '0;
                    r_row <= w_row_end ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + ADDR_W'(1);
                end
            end
            if (w_out_load) begin
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cur  <= t_point'({i_point_x, i_point_y, i_point_z});
            r_addr <= r_col;
            r_emit <= (r_row >= ROW_W'(2)) && (r_col >= ADDR_W'(2));
            r_last <= w_row_end && w_col_end;
            r_crow <= r_row - ROW_W'(1);
            r_ccol <= r_col - ADDR_W'(1);
        end
        if (r_state == S_MEM) begin
            r_k      <= '0;
            r_ax_acc <= '0;
            r_ay_acc <= '0;
            r_az_acc <= '0;
        end
        if (r_state == S_DIFF) begin
            r_ax <= DIFF_W'(w_p.x) - DIFF_W'(w_cc.x);
            r_ay <= DIFF_W'(w_p.y) - DIFF_W'(w_cc.y);
            r_az <= DIFF_W'(w_p.z) - DIFF_W'(w_cc.z);
            r_bx <= DIFF_W'(w_q.x) - DIFF_W'(w_cc.x);
            r_by <= DIFF_W'(w_q.y) - DIFF_W'(w_cc.y);
            r_bz <= DIFF_W'(w_q.z) - DIFF_W'(w_cc.z);
            r_j  <= '0;
        end
        if (r_state == S_MUL) begin
            r_prod[r_j] <= w_ma * w_mb;
            r_j         <= r_j + 3'd1;
        end
        if (r_state == S_TWT && w_done) begin
            r_ax_acc <= r_ax_acc + ACC_W'(w_nrm.x);
            r_ay_acc <= r_ay_acc + ACC_W'(w_nrm.y);
            r_az_acc <= r_az_acc + ACC_W'(w_nrm.z);
            r_k      <= r_k + 3'd1;
        end
        if (r_state == S_FWT && w_done) begin
            r_fin <= w_nrm;
        end
        if (w_out_load) begin
            o_normal_x      <= r_fin.x;
            o_normal_y      <= r_fin.y;
            o_normal_z      <= r_fin.z;
            o_centre_row    <= r_crow;
            o_centre_col    <= r_ccol;
            o_last_of_frame <= r_last;
        end
        if ((r_state == S_MEM && !r_emit) || w_out_load) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_top;
            r_win[4] <= r_mid;
            r_win[5] <= r_cur;
        end
    end

    assign o_out_valid = r_oval;

    `XYZ_ASSERT_NXT(a_beat_mem, i_clk, i_rst_n, w_in_acc, r_state == S_MEM, "beat not read")
    `XYZ_ASSERT_NOW(a_done_wait, i_clk, i_rst_n, w_done,
        r_state == S_TWT || r_state == S_FWT, "stray normaliser result")
    `XYZ_ASSERT_NXT(a_border_idle, i_clk, i_rst_n, r_state == S_MEM && !r_emit,
        r_state == S_IDLE, "border beat not retired")

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for xyz_image_normal_estimator_top: random point images in
// raster order, with a built-in predictor of the 3x3 cross-product normals.
// Depends on xyz_ne_pkg and the estimator RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import xyz_ne_pkg::*;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } vec_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } pt_t;

    typedef struct {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic [ROW_W-1:0]         row;
        logic [ADDR_W-1:0]        col;
        logic                     last;
    } nrm_beat_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [COORD_W-1:0] i_point_x = '0;
    logic signed [COORD_W-1:0] i_point_y = '0;
    logic signed [COORD_W-1:0] i_point_z = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [NORM_W-1:0]  o_normal_x, o_normal_y, o_normal_z;
    logic [ROW_W-1:0]          o_centre_row;
    logic [ADDR_W-1:0]         o_centre_col;
    logic                      o_last_of_frame;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IW-1:0]         i_cfg_idx = REG_WIDTH;
    logic [CFG_DW-1:0]         i_cfg_data = '0;

    xyz_image_normal_estimator_top dut (.*);

    always #2 i_clk = ~i_clk;

    pt_t       point_q[$];
    nrm_beat_t normal_q[$];
    int        errors = 0;
    int        send_idle = 0;
    int        recv_idle = 0;
    int        hold_req = 0;
    int        hold_done = 0;
    int        hold_cnt = 0;

    // predictor state
    vec_t      upper_ls[MAX_WIDTH];
    vec_t      middle_ls[MAX_WIDTH];
    vec_t      win[6];
    int        col_pos = 0, row_pos = 0;
    int        eff_w = 640, eff_h = 480;

    function automatic bit [63:0] isqrt(bit [63:0] v);
        bit [63:0] res = 0;
        bit [63:0] probe = 64'd1 << 62;
        while (probe > v) probe >>= 2;
        while (probe != 0) begin
            if (v >= res + probe) begin
                v -= res + probe;
                res = (res >> 1) + probe;
            end else begin
                res >>= 1;
            end
            probe >>= 2;
        end
        return res;
    endfunction

    function automatic bit [63:0] magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic vec_t unit_vec(vec_t v);
        longint    c[3];
        bit [63:0] m, a, sum, n;
        int        s;
        vec_t      r;
        c[0] = v.x; c[1] = v.y; c[2] = v.z;
        m = magn(c[0]);
        if (magn(c[1]) > m) m = magn(c[1]);
        if (magn(c[2]) > m) m = magn(c[2]);
        s = 0;
        while ((m >> s) >= (64'd1 << 30)) s++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            a = magn(c[i]) >> s;
            c[i] = c[i] < 0 ? -longint'(a) : longint'(a);
            sum += a * a;
        end
        n = isqrt(sum);
        r = '{0, 0, 0};
        if (n == 0) return r;
        for (int i = 0; i < 3; i++) begin
            a = ((magn(c[i]) << NORM_F) * 2 + n) / (2 * n);
            c[i] = c[i] < 0 ? -longint'(a) : longint'(a);
        end
        r.x = c[0]; r.y = c[1]; r.z = c[2];
        return r;
    endfunction

    function automatic vec_t facet(vec_t p, vec_t q, vec_t cc);
        vec_t a, b, r;
        a.x = p.x - cc.x; a.y = p.y - cc.y; a.z = p.z - cc.z;
        b.x = q.x - cc.x; b.y = q.y - cc.y; b.z = q.z - cc.z;
        r.x = a.y * b.z - a.z * b.y;
        r.y = a.z * b.x - a.x * b.z;
        r.z = a.x * b.y - a.y * b.x;
        return unit_vec(r);
    endfunction

    task automatic predict_normal(vec_t cur);
        vec_t      top, mid, acc, t, nv;
        vec_t      ring[9];
        nrm_beat_t e;
        int        c = col_pos, r = row_pos;
        if (c >= eff_w) c = 0;
        if (r >= eff_h) r = 0;
        top = upper_ls[c];
        mid = middle_ls[c];
        upper_ls[c] = mid;
        middle_ls[c] = cur;
        if (r >= 2 && c >= 2) begin
            // neighbours walked around the centre: tc tr cr br bc bl cl tl
            ring = '{win[3], top, mid, cur, win[5], win[2], win[1], win[0], win[3]};
            acc = '{0, 0, 0};
            for (int i = 0; i < 8; i++) begin
                t = facet(ring[i + 1], ring[i], win[4]);
                acc.x += t.x; acc.y += t.y; acc.z += t.z;
            end
            nv = unit_vec(acc);
            e.nx = NORM_W'(nv.x); e.ny = NORM_W'(nv.y); e.nz = NORM_W'(nv.z);
            e.row = ROW_W'(r - 1);
            e.col = ADDR_W'(c - 1);
            e.last = (r == eff_h - 1 && c == eff_w - 1);
            normal_q.push_back(e);
        end
        win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
        win[3] = top; win[4] = mid; win[5] = cur;
        c++;
        if (c >= eff_w) begin
            c = 0;
            r++;
            if (r >= eff_h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (i_rst_n && (!i_in_valid || o_in_ready)) begin
            if (point_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                i_in_valid <= 1'b1;
                i_point_x  <= point_q[0].x;
                i_point_y  <= point_q[0].y;
                i_point_z  <= point_q[0].z;
                void'(point_q.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // accepted input beats feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            predict_normal('{longint'(i_point_x), longint'(i_point_y), longint'(i_point_z)});
    end

    // receiver backpressure, with a single long hold-off
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (hold_req != hold_done) begin
            hold_done   <= hold_req;
            hold_cnt    <= 4000;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= $urandom_range(99) >= recv_idle;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        nrm_beat_t e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (normal_q.size() == 0) begin
                $display("%0t: unexpected beat row %0d col %0d", $realtime, o_centre_row,
                         o_centre_col);
                errors++;
            end else begin
                e = normal_q.pop_front();
                if (o_normal_x !== e.nx || o_normal_y !== e.ny || o_normal_z !== e.nz ||
                    o_centre_row !== e.row || o_centre_col !== e.col ||
                    o_last_of_frame !== e.last) begin
                    $display("%0t: expected n=(%0d,%0d,%0d) rc=(%0d,%0d) last=%0d", $realtime,
                             e.nx, e.ny, e.nz, e.row, e.col, e.last);
                    $display("%0t: actual   n=(%0d,%0d,%0d) rc=(%0d,%0d) last=%0d", $realtime,
                             o_normal_x, o_normal_y, o_normal_z, o_centre_row, o_centre_col,
                             o_last_of_frame);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IW-1:0] idx, int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DW'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_WIDTH) begin
            eff_w = value & 12'hFFF;
            eff_w = eff_w < 3 ? 3 : (eff_w > MAX_WIDTH ? MAX_WIDTH : eff_w);
        end else begin
            eff_h = value & 13'h1FFF;
            eff_h = eff_h < 3 ? 3 : (eff_h > MAX_HEIGHT ? MAX_HEIGHT : eff_h);
        end
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic drain();
        while (point_q.size() > 0 || i_in_valid) @(posedge i_clk);
        while (normal_q.size() > 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
    endtask

    task automatic push_pt(int x, int y, int z);
        pt_t p;
        p.x = COORD_W'(x); p.y = COORD_W'(y); p.z = COORD_W'(z);
        point_q.push_back(p);
    endtask

    // one image's worth of points of a chosen character
    task automatic push_image(int w, int n, int kind);
        int ax = $urandom_range(1, 4000), ay = $urandom_range(1, 4000);
        int bz = $urandom_range(0, 8000) - 4000, cz = $urandom_range(0, 8000) - 4000;
        int base = $urandom_range(0, 200000) - 100000;
        for (int i = 0; i < n; i++) begin
            int c = i % w, r = i / w;
            case (kind)
                0: push_pt($urandom, $urandom, $urandom);
                1: push_pt(base, base, base);
                2: push_pt($urandom_range(0, 63) - 32, $urandom_range(0, 63) - 32,
                           $urandom_range(0, 63) - 32);
                default: push_pt(c * ax - base, r * ay + base,
                                 base + c * bz + r * cz + $urandom_range(0, 40) - 20);
            endcase
        end
    endtask

    initial begin
        int sent, w, h, n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest image: flat, extreme corners, plane
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 3);
        push_image(3, 9, 1);
        for (int i = 0; i < 9; i++)
            if (i % 2) push_pt(-524288, 524287, -524288);
            else push_pt(524287, -524288, 524287);
        push_image(3, 9, 3);
        drain();

        // clamped registers
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 8191);
        push_image(3, 15, 3);
        drain();

        sent = 0;
        while (sent < 1060) begin
            send_idle = sent < 370 ? 19 : (sent < 740 ? 66 : 0);
            recv_idle = sent < 370 ? 66 : (sent < 740 ? 19 : 0);
            w = $urandom_range(3, 8);
            h = $urandom_range(3, 6);
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, h);
            n = $urandom_range(0, 3) == 0 ? $urandom_range(1, w * h * 2) :
                w * h * $urandom_range(1, 2);
            if (sent == 0) hold_req++;
            push_image(w, n, $urandom_range(0, 9) < 2 ? $urandom_range(0, 2) : 3);
            sent += n;
            drain();
        end

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #40000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
